// ===== design/wcs_pkg.sv =====
// package for the washer cycle sequencer: field widths, codes, register map
// and the configuration struct; no dependencies
`default_nettype none

package wcs_pkg;

  // payload field widths
  localparam int unsigned SwitchW = 3;
  localparam int unsigned DurW    = 6;
  localparam int unsigned TickW   = 12;
  localparam int unsigned RepW    = 3;
  localparam int unsigned LenW    = 8;

  // configuration port
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // register indexes (word address)
  localparam logic [1:0] REG_WASH_HALF = 2'd0;
  localparam logic [1:0] REG_DRY_UNITS = 2'd1;
  localparam logic [1:0] REG_BUZZ      = 2'd2;

  // register reset values
  localparam logic [DurW-1:0] WASH_HALF_RST = 6'd4;
  localparam logic [DurW-1:0] DRY_UNITS_RST = 6'd8;
  localparam logic [DurW-1:0] BUZZ_RST      = 6'd4;

  // load switch codes
  localparam logic [SwitchW-1:0] LOAD_LIGHT  = 3'b001;
  localparam logic [SwitchW-1:0] LOAD_MEDIUM = 3'b010;
  localparam logic [SwitchW-1:0] LOAD_HEAVY  = 3'b100;

  // task switch codes
  localparam logic [SwitchW-1:0] TASK_WASH_DRY = 3'b001;
  localparam logic [SwitchW-1:0] TASK_WASH     = 3'b010;
  localparam logic [SwitchW-1:0] TASK_DRY      = 3'b100;

  typedef struct packed {
    logic [DurW-1:0] wash_half_units;
    logic [DurW-1:0] dry_units_per_load;
    logic [DurW-1:0] buzz_units;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/wcs_intf.sv =====
// valid/ready channel interfaces for switch samples and indicator results
// depends on wcs_pkg for field widths
`default_nettype none

interface wcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [wcs_pkg::SwitchW-1:0]  load_switches;
  logic [wcs_pkg::SwitchW-1:0]  task_switches;
  logic                         start_press;
  logic                         stop_press;
  logic                         unit_tick;

  modport source (
    output valid, load_switches, task_switches, start_press, stop_press, unit_tick,
    input  ready
  );
  modport sink (
    input  valid, load_switches, task_switches, start_press, stop_press, unit_tick,
    output ready
  );
endinterface

interface wcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [wcs_pkg::SwitchW-1:0]  load_leds;
  logic                         drum_led;
  logic                         buzzer_on;
  logic                         running;

  modport source (
    output valid, load_leds, drum_led, buzzer_on, running,
    input  ready
  );
  modport sink (
    input  valid, load_leds, drum_led, buzzer_on, running,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/washer_cycle_sequencer_unit.sv =====
// washer cycle sequencer top level: one switch sample in, one indicator result out
// latency: the result of a sample is valid the cycle after its transfer
// throughput: one sample per cycle unless the output stalls; a full result
// register whose result leaves in the same cycle does not block the next transfer
// reset: phase idle, choices and counters cleared, durations 4/8/4 units
// depends on wcs_pkg, wcs_intf (wcs_in_if, wcs_out_if) and wcs_cfg_regs
`default_nettype none

module washer_cycle_sequencer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  wcs_in_if.sink                              in_i,
  wcs_out_if.source                           out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wcs_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [wcs_pkg::ApbDataW-1:0]   pwdata,
  output logic      [wcs_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WASH_ON  = 3'd1,
    PH_WASH_OFF = 3'd2,
    PH_DRY      = 3'd3,
    PH_BUZZ     = 3'd4
  } phase_e;

  wcs_pkg::cfg_t cfg;

  // sequencer state
  phase_e                       phase_q, phase_d;
  logic [wcs_pkg::SwitchW-1:0]  load_q, load_d;
  logic [wcs_pkg::SwitchW-1:0]  task_q, task_d;
  logic [wcs_pkg::RepW-1:0]     rep_q, rep_d;
  logic [wcs_pkg::TickW-1:0]    tick_q, tick_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic [wcs_pkg::SwitchW-1:0]  leds_q, leds_d;
  logic                         drum_q, drum_d;
  logic                         buzz_q, buzz_d;
  logic                         run_q, run_d;

  logic                         accept;

  wcs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the result register acts as the skid stage: take a new sample whenever
  // it is empty or its current result is leaving this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.load_leds = leds_q;
  assign out_o.drum_led  = drum_q;
  assign out_o.buzzer_on = buzz_q;
  assign out_o.running   = run_q;

  always_comb begin
    logic                        load_ok;
    logic                        task_ok;
    logic [1:0]                  eff_load;
    logic [wcs_pkg::LenW-1:0]    dry_len;
    logic [wcs_pkg::LenW-1:0]    raw_len;
    logic [wcs_pkg::LenW-1:0]    phase_len;
    logic [wcs_pkg::TickW-1:0]   tick_inc;
    logic [wcs_pkg::RepW-1:0]    rep_inc;

    phase_d = phase_q;
    load_d  = load_q;
    task_d  = task_q;
    rep_d   = rep_q;
    tick_d  = tick_q;

    load_ok = (in_i.load_switches == wcs_pkg::LOAD_LIGHT) ||
              (in_i.load_switches == wcs_pkg::LOAD_MEDIUM) ||
              (in_i.load_switches == wcs_pkg::LOAD_HEAVY);
    task_ok = (in_i.task_switches == wcs_pkg::TASK_WASH_DRY) ||
              (in_i.task_switches == wcs_pkg::TASK_WASH) ||
              (in_i.task_switches == wcs_pkg::TASK_DRY);

    // heavy load counts as three units
    eff_load = (load_q == wcs_pkg::LOAD_HEAVY) ? 2'd3 : load_q[1:0];
    dry_len  = wcs_pkg::LenW'({6'd0, eff_load} * {2'd0, cfg.dry_units_per_load});

    case (phase_q)
      PH_WASH_ON, PH_WASH_OFF: raw_len = wcs_pkg::LenW'(cfg.wash_half_units);
      PH_DRY:                  raw_len = dry_len;
      default:                 raw_len = wcs_pkg::LenW'(cfg.buzz_units);
    endcase
    // a zero duration still lasts one unit
    phase_len = (raw_len == '0) ? wcs_pkg::LenW'(1) : raw_len;

    tick_inc = tick_q + wcs_pkg::TickW'(1);
    rep_inc  = rep_q + wcs_pkg::RepW'(1);

    if (accept) begin
      if (phase_q == PH_IDLE || phase_q > PH_BUZZ) begin
        // idle: latch one-hot choices, then check start in the same transfer
        phase_d = PH_IDLE;
        if (load_ok) load_d = in_i.load_switches;
        if (task_ok) task_d = in_i.task_switches;
        if (in_i.start_press && load_d != '0 && task_d != '0) begin
          rep_d   = '0;
          tick_d  = '0;
          phase_d = (task_d == wcs_pkg::TASK_DRY) ? PH_DRY : PH_WASH_ON;
        end
      end else if (in_i.stop_press) begin
        // abort wins over a tick
        phase_d = PH_IDLE;
        load_d  = '0;
        task_d  = '0;
        rep_d   = '0;
        tick_d  = '0;
      end else if (in_i.unit_tick) begin
        if (tick_inc >= wcs_pkg::TickW'(phase_len)) begin
          tick_d = '0;
          case (phase_q)
            PH_WASH_ON: phase_d = PH_WASH_OFF;
            PH_WASH_OFF: begin
              // 2L+1 on/off repetitions
              if (rep_inc >= {eff_load, 1'b1}) begin
                rep_d   = '0;
                phase_d = (task_q == wcs_pkg::TASK_WASH_DRY) ? PH_DRY : PH_BUZZ;
              end else begin
                rep_d   = rep_inc;
                phase_d = PH_WASH_ON;
              end
            end
            PH_DRY: phase_d = PH_BUZZ;
            default: begin
              // buzzer done: back to idle, choices kept
              phase_d = PH_IDLE;
              rep_d   = '0;
            end
          endcase
        end else begin
          tick_d = tick_inc;
        end
      end
    end

    // indicators reflect the state after this sample
    leds_d = (phase_d == PH_WASH_ON || phase_d == PH_WASH_OFF || phase_d == PH_DRY)
             ? load_d : '0;
    drum_d = (phase_d == PH_WASH_ON || phase_d == PH_DRY);
    buzz_d = (phase_d == PH_BUZZ);
    run_d  = (phase_d != PH_IDLE);

    out_valid_d = accept ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      load_q      <= '0;
      task_q      <= '0;
      rep_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      leds_q      <= '0;
      drum_q      <= 1'b0;
      buzz_q      <= 1'b0;
      run_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      load_q      <= load_d;
      task_q      <= task_d;
      rep_q       <= rep_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        leds_q <= leds_d;
        drum_q <= drum_d;
        buzz_q <= buzz_d;
        run_q  <= run_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a running cycle always has both choices set
  a_run_has_choices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (load_q != '0 && task_q != '0))
    else $error("running without a load or task choice");

  // repetition counter only counts inside the wash phases
  a_rep_only_in_wash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_WASH_ON && phase_q != PH_WASH_OFF) |-> (rep_q == '0))
    else $error("repetition count left over outside wash");

  // tick counter stays within the LenW bits of a phase length
  a_tick_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q[wcs_pkg::TickW-1:wcs_pkg::LenW] == '0)
    else $error("tick counter ran past any phase length");

  // a stop transfer while running lands in idle
  a_stop_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.stop_press && phase_q != PH_IDLE) |=> (phase_q == PH_IDLE))
    else $error("stop did not abort the running cycle");
`endif

endmodule

`default_nettype wire

// ===== design/wcs_cfg_regs.sv =====
// apb-style register file holding the three phase durations
// depends on wcs_pkg for the register map and cfg_t
`default_nettype none

module wcs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wcs_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [wcs_pkg::ApbDataW-1:0]   pwdata,
  output logic      [wcs_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready,
  output wcs_pkg::cfg_t                       cfg_o
);

  wcs_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[wcs_pkg::ApbAddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wash_half_units    <= wcs_pkg::WASH_HALF_RST;
      cfg_q.dry_units_per_load <= wcs_pkg::DRY_UNITS_RST;
      cfg_q.buzz_units         <= wcs_pkg::BUZZ_RST;
    end else if (wr_en) begin
      case (reg_idx)
        wcs_pkg::REG_WASH_HALF: cfg_q.wash_half_units    <= pwdata[wcs_pkg::DurW-1:0];
        wcs_pkg::REG_DRY_UNITS: cfg_q.dry_units_per_load <= pwdata[wcs_pkg::DurW-1:0];
        wcs_pkg::REG_BUZZ:      cfg_q.buzz_units         <= pwdata[wcs_pkg::DurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      wcs_pkg::REG_WASH_HALF: prdata[wcs_pkg::DurW-1:0] = cfg_q.wash_half_units;
      wcs_pkg::REG_DRY_UNITS: prdata[wcs_pkg::DurW-1:0] = cfg_q.dry_units_per_load;
      wcs_pkg::REG_BUZZ:      prdata[wcs_pkg::DurW-1:0] = cfg_q.buzz_units;
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
